>>> src/cbpa_pkg.sv
package cbpa_pkg;

	localparam int SMALL_BUFFERS = 1024;
	localparam int LARGE_BUFFERS = 128;
	localparam int BATCH         = 32;
	localparam int WAITERS       = 64;

	localparam int LEN_W     = 21;
	localparam int HANDLE_W  = 10;
	localparam int WID_W     = 6;
	localparam int STAT_W    = 4;
	localparam int CNTR_W    = 32;
	localparam int STGT_W    = 11;
	localparam int LTGT_W    = 8;
	localparam int TGT_W     = STGT_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = LEN_W;

	localparam int IDX_W    = $clog2(SMALL_BUFFERS);
	localparam int CNT_W    = $clog2(SMALL_BUFFERS + 1);
	localparam int WQ_IDX_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
	localparam int WQ_CNT_W = $clog2(WAITERS + 1);
	localparam int BATCH_W  = $clog2(BATCH + 1);

	localparam logic [1:0] FN_GET   = 2'd0;
	localparam logic [1:0] FN_PUT   = 2'd1;
	localparam logic [1:0] FN_ABORT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_TARGET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LARGE_TARGET = 2'd2;

	localparam logic [LEN_W-1:0]  RST_SMALL_LIMIT  = 21'd8192;
	localparam logic [STGT_W-1:0] RST_SMALL_TARGET = 11'd128;
	localparam logic [LTGT_W-1:0] RST_LARGE_TARGET = 8'd16;

	typedef enum logic [STAT_W-1:0] {
		ST_CACHE_HIT   = 4'd0,
		ST_CENTRAL_HIT = 4'd1,
		ST_QUEUED      = 4'd2,
		ST_NONE        = 4'd3,
		ST_HANDED      = 4'd4,
		ST_CACHED      = 4'd5,
		ST_TO_CENTRAL  = 4'd6,
		ST_ABORTED     = 4'd7,
		ST_NOT_FOUND   = 4'd8
	} status_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [LEN_W-1:0]    request_length;
		logic [HANDLE_W-1:0] buffer_handle;
		logic [WID_W-1:0]    waiter_id;
		logic                waiter_valid;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] granted_handle;
		logic [WID_W-1:0]    served_waiter;
		logic                size_class;
		logic [CNTR_W-1:0]   cache_hits;
		logic [CNTR_W-1:0]   central_hits;
		logic [CNTR_W-1:0]   retries;
	} rsp_t;

	typedef struct packed {
		logic [1:0]          func;
		logic                cls;
		logic [HANDLE_W-1:0] handle;
		logic [WID_W-1:0]    wid;
		logic                wvalid;
		logic [TGT_W-1:0]    target;
	} cmd_t;

	typedef enum logic [3:0] {
		BS_IDLE, BS_DISPATCH, BS_HIT, BS_MV_RD, BS_MV_WR, BS_SERVE,
		BS_FL_RD, BS_FL_WR, BS_AB_RD, BS_AB_CMP, BS_SH_RD, BS_SH_WR, BS_DONE
	} bstate_t;

	function automatic logic [CNT_W-1:0] cap_of(input logic cls);
		return cls ? CNT_W'(LARGE_BUFFERS) : CNT_W'(SMALL_BUFFERS);
	endfunction

	// ring index (base + off) modulo the class capacity; off never exceeds cap
	function automatic logic [IDX_W-1:0] cen_wrap(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off, input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = {1'b0, CNT_W'(base)} + {1'b0, off};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [WQ_IDX_W-1:0] wq_wrap(input logic [WQ_IDX_W-1:0] base,
			input logic [WQ_CNT_W-1:0] off);
		logic [WQ_CNT_W+1:0] s;
		s = (WQ_CNT_W+2)'(base) + (WQ_CNT_W+2)'(off);
		if (s >= (WQ_CNT_W+2)'(WAITERS)) begin
			s = s - (WQ_CNT_W+2)'(WAITERS);
		end
		return s[WQ_IDX_W-1:0];
	endfunction

endpackage

>>> src/cbpa_front.sv
module cbpa_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  cbpa_pkg::req_t            req,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbpa_pkg::CFG_DAT_W-1:0] cfg_data,
	output logic                      push,
	output cbpa_pkg::cmd_t            push_cmd,
	input  logic                      q_full
);
	import cbpa_pkg::*;

	logic [LEN_W-1:0]  small_limit_q;
	logic [STGT_W-1:0] small_target_q;
	logic [LTGT_W-1:0] large_target_q;
	logic              cls;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_limit_q  <= RST_SMALL_LIMIT;
			small_target_q <= RST_SMALL_TARGET;
			large_target_q <= RST_LARGE_TARGET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SMALL_LIMIT:  small_limit_q  <= cfg_data[LEN_W-1:0];
				CFG_SMALL_TARGET: small_target_q <= cfg_data[STGT_W-1:0];
				CFG_LARGE_TARGET: large_target_q <= cfg_data[LTGT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cls       = (req.request_length > small_limit_q);
	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	always_comb begin
		push_cmd.func   = req.func;
		push_cmd.cls    = cls;
		push_cmd.handle = req.buffer_handle;
		push_cmd.wid    = req.waiter_id;
		push_cmd.wvalid = req.waiter_valid;
		push_cmd.target = cls ? TGT_W'(large_target_q) : small_target_q;
	end

endmodule

>>> src/cbpa_cmd_queue.sv
module cbpa_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cbpa_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop,
	output cbpa_pkg::cmd_t pop_cmd
);
	import cbpa_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_cmd   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> src/cbpa_back.sv
module cbpa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  cbpa_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cbpa_pkg::rsp_t rsp
);
	import cbpa_pkg::*;

	localparam int MEM_D = 2 * SMALL_BUFFERS;
	localparam int WQ_D  = 2 * WAITERS;

	// storage; central FIFO entries past the fill mark still hold their index
	logic [HANDLE_W-1:0] cen_mem [MEM_D];
	logic [HANDLE_W-1:0] stk_mem [MEM_D];
	logic [WID_W-1:0]    wq_mem  [WQ_D];

	bstate_t st_q, st_d;
	cmd_t    cmd_q;

	logic [IDX_W-1:0]    cen_head_q [2];
	logic [CNT_W-1:0]    cen_cnt_q  [2];
	logic [CNT_W-1:0]    cen_fill_q [2];
	logic [CNT_W-1:0]    stk_cnt_q  [2];
	logic [WQ_IDX_W-1:0] wq_head_q  [2];
	logic [WQ_CNT_W-1:0] wq_cnt_q   [2];
	logic [CNTR_W-1:0]   cache_hits_q   [2];
	logic [CNTR_W-1:0]   central_hits_q [2];
	logic [CNTR_W-1:0]   retries_q      [2];

	logic [BATCH_W-1:0]  left_q;
	logic [WQ_CNT_W-1:0] idx_q;

	status_t             res_status_q;
	logic [HANDLE_W-1:0] res_granted_q;
	logic [WID_W-1:0]    res_served_q;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [HANDLE_W-1:0] cen_rdata_q, stk_rdata_q;
	logic [WID_W-1:0]    wq_rdata_q;
	logic                cen_unw_q;
	logic [IDX_W-1:0]    cen_raidx_q;

	logic                c;
	logic [CNT_W-1:0]    cap, ccnt, scnt, stk_new;
	logic [IDX_W-1:0]    chead, ctail, chead_nx;
	logic [WQ_IDX_W-1:0] whead;
	logic [WQ_CNT_W-1:0] wcnt;
	logic [BATCH_W-1:0]  nbatch, get_sz, put_sz;
	logic                stk_full, cen_full, flush, ab_match, rsp_free;
	logic [HANDLE_W-1:0] cen_val;

	logic                cen_we, stk_we, wq_we;
	logic [IDX_W:0]      cen_waddr, cen_raddr, stk_waddr, stk_raddr;
	logic [HANDLE_W-1:0] cen_wdata, stk_wdata;
	logic [WQ_IDX_W:0]   wq_waddr, wq_raddr;
	logic [WID_W-1:0]    wq_wdata;
	logic [WQ_CNT_W-1:0] wq_roff;

	assign c        = cmd_q.cls;
	assign cap      = cap_of(c);
	assign ccnt     = cen_cnt_q[c];
	assign scnt     = stk_cnt_q[c];
	assign chead    = cen_head_q[c];
	assign whead    = wq_head_q[c];
	assign wcnt     = wq_cnt_q[c];
	assign ctail    = cen_wrap(chead, ccnt, cap);
	assign chead_nx = cen_wrap(chead, CNT_W'(1), cap);
	assign stk_full = (scnt >= cap);
	assign cen_full = (ccnt >= cap);
	assign stk_new  = stk_full ? scnt : scnt + CNT_W'(1);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (cmd_q.target == '0) begin
			nbatch = BATCH_W'(1);
		end else if (cmd_q.target > TGT_W'(BATCH)) begin
			nbatch = BATCH_W'(BATCH);
		end else begin
			nbatch = BATCH_W'(cmd_q.target);
		end
		get_sz = (ccnt < CNT_W'(nbatch)) ? BATCH_W'(ccnt) : nbatch;
		put_sz = (cmd_q.target < TGT_W'(BATCH)) ? BATCH_W'(cmd_q.target)
			: BATCH_W'(BATCH);
	end

	assign flush    = ({1'b0, stk_new} >= ((CNT_W+1)'(cmd_q.target) + (CNT_W+1)'(put_sz)));
	assign cen_val  = cen_unw_q ? HANDLE_W'(cen_raidx_q) : cen_rdata_q;
	assign ab_match = (wq_rdata_q == cmd_q.wid);
	assign q_pop    = (st_q == BS_IDLE) && q_valid;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BS_IDLE: if (q_valid) begin
				st_d = BS_DISPATCH;
			end
			BS_DISPATCH: begin
				case (cmd_q.func)
					FN_GET: begin
						if (scnt != '0) st_d = BS_HIT;
						else if (get_sz == '0) st_d = BS_DONE;
						else st_d = BS_MV_RD;
					end
					FN_PUT: begin
						if (wcnt != '0) st_d = BS_SERVE;
						else if (cmd_q.target == '0) st_d = BS_DONE;
						else if (flush) st_d = BS_FL_RD;
						else st_d = BS_DONE;
					end
					FN_ABORT: st_d = (wcnt == '0) ? BS_DONE : BS_AB_RD;
					default:  st_d = BS_DONE;
				endcase
			end
			BS_HIT:    st_d = BS_DONE;
			BS_SERVE:  st_d = BS_DONE;
			BS_MV_RD:  st_d = BS_MV_WR;
			BS_MV_WR:  st_d = (left_q == '0) ? BS_DONE : BS_MV_RD;
			BS_FL_RD:  st_d = BS_FL_WR;
			BS_FL_WR:  st_d = (left_q == '0) ? BS_DONE : BS_FL_RD;
			BS_AB_RD:  st_d = BS_AB_CMP;
			BS_AB_CMP: begin
				if (ab_match) begin
					st_d = ((idx_q + WQ_CNT_W'(1)) < wcnt) ? BS_SH_RD : BS_DONE;
				end else begin
					st_d = ((idx_q + WQ_CNT_W'(1)) >= wcnt) ? BS_DONE : BS_AB_RD;
				end
			end
			BS_SH_RD:  st_d = BS_SH_WR;
			BS_SH_WR:  st_d = (((WQ_CNT_W+1)'(idx_q) + (WQ_CNT_W+1)'(2)) >=
				(WQ_CNT_W+1)'(wcnt)) ? BS_DONE : BS_SH_RD;
			BS_DONE:   if (rsp_free) begin
				st_d = BS_IDLE;
			end
			default:   st_d = BS_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		cen_we    = 1'b0;
		cen_wdata = cmd_q.handle;
		stk_we    = 1'b0;
		stk_wdata = cmd_q.handle;
		wq_we     = 1'b0;
		wq_wdata  = cmd_q.wid;
		wq_waddr  = {c, wq_wrap(whead, wcnt)};
		wq_roff   = '0;
		case (st_q)
			BS_DISPATCH: begin
				if (cmd_q.func == FN_GET && scnt == '0 && get_sz == '0 &&
						cmd_q.wvalid && wcnt < WQ_CNT_W'(WAITERS)) begin
					wq_we = 1'b1;
				end
				if (cmd_q.func == FN_PUT && wcnt == '0) begin
					if (cmd_q.target == '0) begin
						cen_we = !cen_full;
					end else begin
						stk_we = !stk_full;
					end
				end
			end
			BS_MV_WR: begin
				stk_we    = (left_q != '0) && !stk_full;
				stk_wdata = cen_val;
			end
			BS_FL_WR: begin
				cen_we    = !cen_full;
				cen_wdata = stk_rdata_q;
			end
			BS_AB_RD: wq_roff = idx_q;
			BS_SH_RD: wq_roff = idx_q + WQ_CNT_W'(1);
			BS_SH_WR: begin
				wq_we    = 1'b1;
				wq_wdata = wq_rdata_q;
				wq_waddr = {c, wq_wrap(whead, idx_q)};
			end
			default: ;
		endcase
	end

	assign cen_waddr = {c, ctail};
	assign cen_raddr = {c, chead};
	assign stk_waddr = {c, scnt[IDX_W-1:0]};
	assign stk_raddr = {c, IDX_W'(scnt - CNT_W'(1))};
	assign wq_raddr  = {c, wq_wrap(whead, wq_roff)};

	always_ff @(posedge clk) begin
		if (cen_we) begin
			cen_mem[cen_waddr] <= cen_wdata;
		end
		cen_rdata_q <= cen_mem[cen_raddr];
		cen_raidx_q <= chead;
		cen_unw_q   <= (CNT_W'(chead) >= cen_fill_q[c]);
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (wq_we) begin
			wq_mem[wq_waddr] <= wq_wdata;
		end
		wq_rdata_q <= wq_mem[wq_raddr];
	end

	// command and result payload
	always_ff @(posedge clk) begin
		case (st_q)
			BS_IDLE: if (q_valid) begin
				cmd_q <= q_cmd;
			end
			BS_DISPATCH: begin
				res_granted_q <= '0;
				res_served_q  <= '0;
				res_status_q  <= ST_NONE;
				case (cmd_q.func)
					FN_GET: if (scnt == '0 && get_sz == '0 && cmd_q.wvalid &&
							wcnt < WQ_CNT_W'(WAITERS)) begin
						res_status_q <= ST_QUEUED;
					end
					FN_PUT: begin
						if (wcnt != '0) res_status_q <= ST_HANDED;
						else if (cmd_q.target == '0) res_status_q <= ST_TO_CENTRAL;
						else res_status_q <= ST_CACHED;
					end
					FN_ABORT: res_status_q <= ST_NOT_FOUND;
					default: ;
				endcase
			end
			BS_HIT: begin
				res_granted_q <= stk_rdata_q;
				res_status_q  <= ST_CACHE_HIT;
			end
			BS_MV_WR: if (left_q == '0) begin
				res_granted_q <= cen_val;
				res_status_q  <= ST_CENTRAL_HIT;
			end
			BS_SERVE: begin
				res_granted_q <= cmd_q.handle;
				res_served_q  <= wq_rdata_q;
			end
			BS_AB_CMP: if (ab_match) begin
				res_status_q <= ST_ABORTED;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == BS_DONE && rsp_free) begin
			rsp_q.status         <= res_status_q;
			rsp_q.granted_handle <= res_granted_q;
			rsp_q.served_waiter  <= res_served_q;
			rsp_q.size_class     <= c;
			rsp_q.cache_hits     <= cache_hits_q[c];
			rsp_q.central_hits   <= central_hits_q[c];
			rsp_q.retries        <= retries_q[c];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BS_IDLE;
			rsp_valid_q <= 1'b0;
			left_q      <= '0;
			idx_q       <= '0;
			for (int k = 0; k < 2; k++) begin
				cen_head_q[k]     <= '0;
				cen_cnt_q[k]      <= cap_of(k[0]);
				cen_fill_q[k]     <= '0;
				stk_cnt_q[k]      <= '0;
				wq_head_q[k]      <= '0;
				wq_cnt_q[k]       <= '0;
				cache_hits_q[k]   <= '0;
				central_hits_q[k] <= '0;
				retries_q[k]      <= '0;
			end
		end else begin
			st_q <= st_d;
			if (st_q == BS_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cen_we) begin
				cen_cnt_q[c] <= ccnt + CNT_W'(1);
				if (cen_fill_q[c] < cap) begin
					cen_fill_q[c] <= cen_fill_q[c] + CNT_W'(1);
				end
			end
			if (wq_we && st_q == BS_DISPATCH) begin
				wq_cnt_q[c]  <= wcnt + WQ_CNT_W'(1);
				retries_q[c] <= retries_q[c] + CNTR_W'(1);
			end
			case (st_q)
				BS_DISPATCH: begin
					idx_q <= '0;
					case (cmd_q.func)
						FN_GET: begin
							if (scnt != '0) begin
								stk_cnt_q[c] <= scnt - CNT_W'(1);
							end else begin
								left_q <= get_sz - BATCH_W'(1);
							end
						end
						FN_PUT: begin
							if (wcnt != '0) begin
								wq_head_q[c] <= wq_wrap(whead, WQ_CNT_W'(1));
								wq_cnt_q[c]  <= wcnt - WQ_CNT_W'(1);
							end else if (cmd_q.target != '0) begin
								stk_cnt_q[c] <= stk_new;
								left_q       <= put_sz - BATCH_W'(1);
							end
						end
						default: ;
					endcase
				end
				BS_HIT: cache_hits_q[c] <= cache_hits_q[c] + CNTR_W'(1);
				BS_MV_RD: begin
					cen_head_q[c] <= chead_nx;
					cen_cnt_q[c]  <= ccnt - CNT_W'(1);
				end
				BS_MV_WR: begin
					if (left_q == '0) begin
						central_hits_q[c] <= central_hits_q[c] + CNTR_W'(1);
					end else begin
						left_q <= left_q - BATCH_W'(1);
						if (!stk_full) begin
							stk_cnt_q[c] <= scnt + CNT_W'(1);
						end
					end
				end
				BS_FL_RD: stk_cnt_q[c] <= scnt - CNT_W'(1);
				BS_FL_WR: if (left_q != '0) begin
					left_q <= left_q - BATCH_W'(1);
				end
				BS_AB_CMP: begin
					if (ab_match) begin
						if ((idx_q + WQ_CNT_W'(1)) >= wcnt) begin
							wq_cnt_q[c] <= wcnt - WQ_CNT_W'(1);
						end
					end else begin
						idx_q <= idx_q + WQ_CNT_W'(1);
					end
				end
				BS_SH_WR: begin
					idx_q <= idx_q + WQ_CNT_W'(1);
					if (((WQ_CNT_W+1)'(idx_q) + (WQ_CNT_W+1)'(2)) >= (WQ_CNT_W+1)'(wcnt)) begin
						wq_cnt_q[c] <= wcnt - WQ_CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> src/cached_buffer_pool_allocator_unit.sv
// Two-class buffer pool with a per-class local cache.
// Request channel (req_valid/req_stall/req): one get, put or abort per transfer;
// the length picks the small or large class. Response channel
// (rsp_valid/rsp_stall/rsp): exactly one result per request, in order.
// Config channel (cfg_valid/cfg_ready): register index and data, always ready;
// write only while no request is in flight.
// A front stage classifies requests into a two-entry command queue; a back-end
// sequencer executes them against single-port-read memories, one access a cycle.
// Each request passes through dispatch and a done state; a cache hit or a put
// handed to a waiter adds one step, a refill or flush of n handles (n up to 32)
// adds a read and a write per handle, and an abort adds a read and a compare per
// waiter scanned, then a read and a write per waiter shifted.
// Throughput is set by the back-end sequencer: one request at a time.
// Reset: central pools full with handles in order, caches and wait queues
// empty, counters zero; no clearing pass is needed.
// A stalled response holds; the sequencer then stops and the command queue
// fills, after which req_stall rises.
module cached_buffer_pool_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  cbpa_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output cbpa_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbpa_pkg::CFG_DAT_W-1:0] cfg_data
);
	import cbpa_pkg::*;

	logic q_push, q_full, q_valid, q_pop;
	cmd_t push_cmd, pop_cmd;

	cbpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	cbpa_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (pop_cmd)
	);

	cbpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("command pushed into full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("command popped from empty queue");

	a_served_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_HANDED) |-> (rsp.served_waiter == '0))
		else $error("waiter reported without handoff");

	a_granted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == ST_QUEUED || rsp.status == ST_NONE ||
		rsp.status == ST_CACHED || rsp.status == ST_TO_CENTRAL ||
		rsp.status == ST_ABORTED || rsp.status == ST_NOT_FOUND))
		|-> (rsp.granted_handle == '0)) else $error("handle reported without grant");

endmodule
